// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_n, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error("check failed");
// condition that must never hold
`define ASSERT_NEVER(lbl, clk_s, rst_n, cond) `ASSERT_AT(lbl, clk_s, rst_n, !(cond))
`endif

// ----- rtl/ptsb_pkg.sv -----
// shared types, constants and tables of the point to scan binner
// no dependencies
package ptsb_pkg;
	localparam int NUM_BINS = 4096;
	localparam int COORD_BITS = 18;
	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int RANGE_W = 18;
	localparam int BINNUM_W = 12;
	localparam int CFG_W = 19;
	localparam int CFG_IDX_W = 3;
	localparam logic [RANGE_W-1:0] EMPTY_RANGE = '1;

	localparam int SQ_W = 2 * COORD_BITS + 1;
	localparam int SQRT_TOP = ((SQ_W - 1) / 2) * 2;
	localparam int SQRT_ITERS = SQRT_TOP / 2 + 1;
	localparam int CORDIC_STEPS = 25;
	localparam int ITER_N = (SQRT_ITERS > CORDIC_STEPS) ? SQRT_ITERS : CORDIC_STEPS;
	localparam int DIV_W = 20;
	localparam int CNT_MIN = 6;
	localparam int CNT_W = (BIN_W > CNT_MIN) ? BIN_W : CNT_MIN;
	localparam int PW = COORD_BITS + 1;
	localparam int CV_W = 46;
	localparam int Z_W = 28;
	localparam int NORM_BIT = 40;
	localparam int SH_W = 6;
	localparam int BEAR_W = 20;
	localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd6;

	typedef enum logic [2:0] {
		ST_BINNED = 3'd0,
		ST_HEIGHT = 3'd1,
		ST_RLOW = 3'd2,
		ST_RHIGH = 3'd3,
		ST_ANGLE = 3'd4,
		ST_READ = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_MUL, S_ITER, S_CHECK, S_DIV, S_RD, S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic iter;
		logic check;
		logic div;
		logic finish;
		logic clr;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic accept_pt;
		logic out_free;
	} sts_t;

	// atan(2^-i) in q24 rad
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0: v = 28'sd13176795;
			5'd1: v = 28'sd7778716;
			5'd2: v = 28'sd4110060;
			5'd3: v = 28'sd2086331;
			5'd4: v = 28'sd1047214;
			5'd5: v = 28'sd524117;
			5'd6: v = 28'sd262123;
			5'd7: v = 28'sd131069;
			5'd8: v = 28'sd65536;
			5'd9: v = 28'sd32768;
			5'd10: v = 28'sd16384;
			5'd11: v = 28'sd8192;
			5'd12: v = 28'sd4096;
			5'd13: v = 28'sd2048;
			5'd14: v = 28'sd1024;
			5'd15: v = 28'sd512;
			5'd16: v = 28'sd256;
			5'd17: v = 28'sd128;
			5'd18: v = 28'sd64;
			5'd19: v = 28'sd32;
			5'd20: v = 28'sd16;
			5'd21: v = 28'sd8;
			5'd22: v = 28'sd4;
			5'd23: v = 28'sd2;
			5'd24: v = 28'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// ----- rtl/point_to_scan_binner.sv -----
// top level of the point to scan binner: registers, sequencer, datapath
// depends on ptsb_pkg, ptsb_ctrl, ptsb_dp, assert_macros.svh
//
// bins lidar points by bearing and keeps the nearest planar range per bin.
// input channel (in_valid/in_ready) takes one word: a point, or a read of
// one bin that returns it and empties it. output channel (out_valid/out_ready)
// gives one word per input word, in order.
// one item is worked on at a time: a point goes through multiply steps,
// 25 shared cordic and square root steps, a check step, 20 divider steps,
// a bin store read and a finish step that updates the bin; a rejected
// point skips the divider and store read; a read goes through the
// multiply steps, the store read and the finish step. a new item is taken
// only once the last one is done and the sequencer is back in idle.
// the config port (cfg_valid/cfg_ready) writes a register at any time; it is
// always ready. after reset the bin store is swept to empty, one bin a cycle,
// all 4096 bins, during which in_ready stays low. a stalled receiver holds the
// result in the output register; the next item is taken and worked on, and
// waits at its end until the output register frees up.
`include "assert_macros.svh"
module point_to_scan_binner import ptsb_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic [BINNUM_W-1:0]          read_bin,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [BINNUM_W-1:0]          bin_number,
	output logic [RANGE_W-1:0]           range_value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);
	logic signed [17:0] min_z_q, max_z_q;
	logic [RANGE_W-1:0] rng_lo_q, rng_hi_q;
	logic signed [18:0] ang_lo_q, ang_hi_q;
	logic [18:0] angle_step_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_z_q <= -18'sd410;
			max_z_q <= 18'sd102;
			rng_lo_q <= 18'd410;
			rng_hi_q <= 18'd102400;
			ang_lo_q <= -19'sd205783;
			ang_hi_q <= 19'sd205783;
			angle_step_q <= 19'd197;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_Z: min_z_q <= cfg_data[17:0];
				CFG_MAX_Z: max_z_q <= cfg_data[17:0];
				CFG_RANGE_MIN: rng_lo_q <= cfg_data[17:0];
				CFG_RANGE_MAX: rng_hi_q <= cfg_data[17:0];
				CFG_ANGLE_MIN: ang_lo_q <= cfg_data;
				CFG_ANGLE_MAX: ang_hi_q <= cfg_data;
				CFG_ANGLE_STEP: angle_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptsb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.read_bin    (read_bin),
		.min_z       (min_z_q),
		.max_z       (max_z_q),
		.rng_lo      (rng_lo_q),
		.rng_hi      (rng_hi_q),
		.ang_lo      (ang_lo_q),
		.ang_hi      (ang_hi_q),
		.angle_step  (angle_step_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.bin_number  (bin_number),
		.range_value (range_value)
	);

	// one item at a time
	`ASSERT_AT(a_one_item, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`ASSERT_NEVER(a_status_code, clk, arst_n, out_valid && status > ST_READ)
	// rejected points report bin zero
	`ASSERT_NEVER(a_reject_bin, clk, arst_n, out_valid && status > ST_BINNED && status < ST_READ && bin_number != '0)
endmodule

// ----- rtl/ptsb_ram.sv -----
// generic single port ram with registered read
// no dependencies
module ptsb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/ptsb_ctrl.sv -----
// sequencer of the point to scan binner
// depends on ptsb_pkg
module ptsb_ctrl import ptsb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	ctrl_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q + CNT_W'(1);
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == CNT_W'(NUM_BINS - 1)) begin
					state_d = S_IDLE;
					cnt_d = '0;
				end
			end
			S_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (cnt_q == CNT_W'(3)) begin
					state_d = sts.is_read ? S_RD : S_ITER;
					cnt_d = '0;
				end
			end
			S_ITER: begin
				if (cnt_q == CNT_W'(ITER_N - 1)) begin
					state_d = S_CHECK;
					cnt_d = '0;
				end
			end
			S_CHECK: begin
				cnt_d = '0;
				state_d = sts.accept_pt ? S_DIV : S_FIN;
			end
			S_DIV: begin
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					state_d = S_RD;
					cnt_d = '0;
				end
			end
			S_RD: begin
				cnt_d = '0;
				state_d = S_FIN;
			end
			S_FIN: begin
				cnt_d = '0;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d = '0;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.cnt = cnt_q;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.mul = (state_q == S_MUL);
		cmd.iter = (state_q == S_ITER);
		cmd.check = (state_q == S_CHECK);
		cmd.div = (state_q == S_DIV);
		cmd.finish = (state_q == S_FIN) && sts.out_free;
		cmd.clr = (state_q == S_CLEAR);
		in_ready = (state_q == S_IDLE);
	end
endmodule

// ----- rtl/ptsb_dp.sv -----
// datapath: squares, square root, bearing cordic, bin divider, bin store
// depends on ptsb_pkg and ptsb_ram
module ptsb_dp import ptsb_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic [BINNUM_W-1:0]          read_bin,
	input  logic signed [17:0]           min_z,
	input  logic signed [17:0]           max_z,
	input  logic [RANGE_W-1:0]           rng_lo,
	input  logic [RANGE_W-1:0]           rng_hi,
	input  logic signed [18:0]           ang_lo,
	input  logic signed [18:0]           ang_hi,
	input  logic [18:0]                  angle_step,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [BINNUM_W-1:0]          bin_number,
	output logic [RANGE_W-1:0]           range_value
);
	logic req_q, hgt_ok_q, zero_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [2*COORD_BITS-1:0] xx_q, yy_q;
	logic [SQ_W-1:0] s_q, rem_q, res_q, bit_q;
	logic [2*RANGE_W-1:0] lo_q, hi_q;
	logic signed [CV_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0] cz_q;
	status_t stat_q;
	logic [DIV_W-1:0] quo_q, drem_q;
	logic out_valid_q;
	logic [2:0] status_q;
	logic [BINNUM_W-1:0] bin_q;
	logic [RANGE_W-1:0] range_q;

	// magnitudes for the squares
	logic [COORD_BITS-1:0] ax, ay;
	assign ax = x_q[COORD_BITS-1] ? COORD_BITS'(-x_q) : x_q;
	assign ay = y_q[COORD_BITS-1] ? COORD_BITS'(-y_q) : y_q;

	// cordic preparation: fold into the right half plane, then normalize
	logic signed [PW-1:0] xe, ye, rx, ry;
	logic [PW-1:0] ary, m;
	logic signed [Z_W-1:0] z0;
	logic [SH_W-1:0] msb, sh;
	always_comb begin
		xe = PW'(x_q);
		ye = PW'(y_q);
		rx = xe;
		ry = ye;
		z0 = '0;
		if (x_q < 0) begin
			if (y_q >= 0) begin
				rx = ye;
				ry = -xe;
				z0 = HALF_PI_Q24;
			end else begin
				rx = -ye;
				ry = xe;
				z0 = -HALF_PI_Q24;
			end
		end
		ary = ry[PW-1] ? PW'(-ry) : PW'(ry);
		m = (PW'(rx) > ary) ? PW'(rx) : ary;
		msb = '0;
		for (int i = 0; i < PW; i++) begin
			if (m[i]) begin
				msb = SH_W'(i);
			end
		end
		sh = SH_W'(NORM_BIT) - msb;
	end

	// one cordic step
	logic [4:0] ci;
	logic signed [CV_W-1:0] dx, dy;
	assign ci = cmd.cnt[4:0];
	assign dx = cx_q >>> ci;
	assign dy = cy_q >>> ci;

	// one square root step
	logic [SQ_W-1:0] trial;
	assign trial = res_q + bit_q;

	// bearing and acceptance
	logic signed [Z_W-1:0] zr;
	logic signed [BEAR_W-1:0] bear;
	logic signed [BEAR_W:0] diff;
	status_t rej;
	assign zr = (cz_q + Z_W'(128)) >>> 8;
	assign bear = zero_q ? '0 : BEAR_W'(zr);
	assign diff = (BEAR_W+1)'(bear) - (BEAR_W+1)'(ang_lo);
	always_comb begin
		if (!hgt_ok_q) begin
			rej = ST_HEIGHT;
		end else if (s_q < SQ_W'(lo_q)) begin
			rej = ST_RLOW;
		end else if (s_q > SQ_W'(hi_q)) begin
			rej = ST_RHIGH;
		end else if (bear < BEAR_W'(ang_lo) || bear > BEAR_W'(ang_hi)) begin
			rej = ST_ANGLE;
		end else begin
			rej = ST_BINNED;
		end
	end

	// one divider step
	logic [18:0] step_eff;
	logic [DIV_W:0] dtmp;
	assign step_eff = (angle_step == '0) ? 19'd1 : angle_step;
	assign dtmp = {drem_q, quo_q[DIV_W-1]};

	// final result and bin update
	logic [RANGE_W-1:0] rv, rdata;
	logic in_range, f_we;
	logic [2:0] f_stat;
	logic [BINNUM_W-1:0] f_bin;
	logic [RANGE_W-1:0] f_rv, f_wdata;
	assign rv = (res_q > SQ_W'(EMPTY_RANGE)) ? EMPTY_RANGE : res_q[RANGE_W-1:0];
	assign in_range = quo_q < DIV_W'(NUM_BINS);
	always_comb begin
		f_we = 1'b0;
		f_wdata = rv;
		f_bin = '0;
		f_rv = rv;
		f_stat = stat_q;
		if (req_q) begin
			f_stat = ST_READ;
			f_bin = quo_q[BINNUM_W-1:0];
			f_rv = in_range ? rdata : EMPTY_RANGE;
			f_we = in_range;
			f_wdata = EMPTY_RANGE;
		end else if (stat_q == ST_BINNED) begin
			if (!in_range) begin
				f_stat = ST_ANGLE;
			end else begin
				f_bin = quo_q[BINNUM_W-1:0];
				f_we = rv < rdata;
			end
		end
	end

	ptsb_ram #(.WIDTH(RANGE_W), .DEPTH(NUM_BINS)) u_bins (
		.clk   (clk),
		.we    (cmd.clr || (cmd.finish && f_we)),
		.addr  (cmd.clr ? cmd.cnt[BIN_W-1:0] : quo_q[BIN_W-1:0]),
		.wdata (cmd.clr ? EMPTY_RANGE : f_wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			x_q <= pos_x;
			y_q <= pos_y;
			hgt_ok_q <= (pos_z >= min_z) && (pos_z <= max_z);
			quo_q <= DIV_W'(read_bin);
		end
		if (cmd.mul) begin
			case (cmd.cnt[1:0])
				2'd0: begin
					xx_q <= ax * ax;
					cx_q <= CV_W'(rx) <<< sh;
					cy_q <= CV_W'(ry) <<< sh;
					cz_q <= z0;
					zero_q <= (x_q == '0) && (y_q == '0);
				end
				2'd1: yy_q <= ay * ay;
				2'd2: begin
					s_q <= SQ_W'(xx_q) + SQ_W'(yy_q);
					lo_q <= rng_lo * rng_lo;
				end
				default: begin
					hi_q <= rng_hi * rng_hi;
					rem_q <= s_q;
					res_q <= '0;
					bit_q <= SQ_W'(1) << SQRT_TOP;
				end
			endcase
		end
		if (cmd.iter) begin
			if (cmd.cnt < CNT_W'(CORDIC_STEPS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + dy;
					cy_q <= cy_q - dx;
					cz_q <= cz_q + atan_entry(ci);
				end else begin
					cx_q <= cx_q - dy;
					cy_q <= cy_q + dx;
					cz_q <= cz_q - atan_entry(ci);
				end
			end
			if (bit_q != '0) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
		if (cmd.check) begin
			stat_q <= rej;
			quo_q <= DIV_W'(diff);
			drem_q <= '0;
		end
		if (cmd.div) begin
			if (dtmp >= (DIV_W+1)'(step_eff)) begin
				drem_q <= DIV_W'(dtmp - (DIV_W+1)'(step_eff));
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				drem_q <= dtmp[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			status_q <= f_stat;
			bin_q <= f_bin;
			range_q <= f_rv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.is_read = req_q;
	assign sts.accept_pt = (rej == ST_BINNED);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign bin_number = bin_q;
	assign range_value = range_q;
endmodule
